/* rtl/core/scsf_pkg.sv */
`timescale 1ns / 1ps

package scsf_pkg;

   localparam int PATTERN_MAX_DEF = 256;

   localparam int PLEN_W  = 9;
   localparam int REM_W   = PLEN_W + 1;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 3;

   // divider: four dividend bits per cycle over a 32-bit dividend
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = DATA_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_START = 3'd1,
      PH_WRITE = 3'd2,
      PH_CLOSE = 3'd3,
      PH_FAIL  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      M_NEW     = 2'd0,
      M_CONNECT = 2'd1,
      M_SEND    = 2'd2,
      M_CLOSE   = 2'd3
   } method_type;

   localparam logic [2:0] RESP_NEW     = 3'd0;
   localparam logic [2:0] RESP_CONNECT = 3'd1;
   localparam logic [2:0] RESP_SEND    = 3'd2;
   localparam logic [2:0] RESP_CLOSE   = 3'd3;
   localparam logic [2:0] RESP_ERROR   = 3'd4;

   localparam logic OP_TICK = 1'b0;

   typedef enum logic [1:0] {
      WAKE_NONE     = 2'd0,
      WAKE_NOW      = 2'd1,
      WAKE_INTERVAL = 2'd2
   } wake_type;

   typedef enum logic [2:0] {
      ST_TICK       = 3'd0,
      ST_ACCEPTED   = 3'd1,
      ST_STALE      = 3'd2,
      ST_UNEXPECTED = 3'd3,
      ST_FAILED     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_SOURCE_PORT  = 3'd0,
      CSR_DEST_ADDRESS = 3'd1,
      CSR_DEST_PORT    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_TOTAL_BYTES  = 3'd4,
      CSR_CHUNK_MAX    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CS_WAIT   = 2'd0,
      CS_DIV    = 2'd1,
      CS_COMMIT = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/core/stream_connection_sender_fsm.sv */
`timescale 1ns / 1ps

// Client side of a socket request exchange, used as a traffic generator. Each
// input word is a timer tick or a response from the socket layer; each gives
// exactly one result word carrying the request issued (new, connect, send or
// close), the wanted wake-up and the response status. A tick in the writing
// phase with bytes still to send is accepted, runs through the remainder unit
// that forms bytes sent mod pattern length four bits a cycle, then commits;
// any other word is accepted, then commits. Results sit in an output register,
// so the next word is accepted while one waits to be taken. The user must
// write configuration to csr_ only while no word is in flight; not enforced.
module stream_connection_sender_fsm #(
   parameter int PATTERN_MAX = scsf_pkg::PATTERN_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [scsf_pkg::INDEX_W-1:0] csr_index,
   input  logic [scsf_pkg::DATA_W-1:0]  csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [2:0]                   req_resp_method,
   input  logic [31:0]                  req_resp_sequence,
   input  logic [7:0]                   req_resp_socket_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_has_request,
   output logic [1:0]                   rsp_req_method,
   output logic [7:0]                   rsp_req_socket,
   output logic [31:0]                  rsp_req_sequence,
   output logic [7:0]                   rsp_payload_start,
   output logic [15:0]                  rsp_payload_length,
   output logic [15:0]                  rsp_req_src_port,
   output logic [31:0]                  rsp_req_dst_address,
   output logic [15:0]                  rsp_req_dst_port,
   output logic [1:0]                   rsp_wake,
   output logic [2:0]                   rsp_response_status
);

   scsf_pkg::dp_cmd_type    cmd;
   scsf_pkg::dp_status_type status;

   scsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scsf_dpath #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_resp_method     (req_resp_method),
      .req_resp_sequence   (req_resp_sequence),
      .req_resp_socket_id  (req_resp_socket_id),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_has_request     (rsp_has_request),
      .rsp_req_method      (rsp_req_method),
      .rsp_req_socket      (rsp_req_socket),
      .rsp_req_sequence    (rsp_req_sequence),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_req_src_port    (rsp_req_src_port),
      .rsp_req_dst_address (rsp_req_dst_address),
      .rsp_req_dst_port    (rsp_req_dst_port),
      .rsp_wake            (rsp_wake),
      .rsp_response_status (rsp_response_status),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

/* rtl/core/scsf_ctrl.sv */
`timescale 1ns / 1ps

module scsf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  scsf_pkg::dp_status_type status,
   output scsf_pkg::dp_cmd_type   cmd
);

   scsf_pkg::ctrl_state_type state_ff, state_in;
   logic [scsf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            cnt_last;

   assign cnt_last = (cnt_ff == scsf_pkg::DIV_CNT_W'(scsf_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scsf_pkg::CS_WAIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scsf_pkg::CS_WAIT: begin
            if (req_valid) begin
               state_in = status.need_div ? scsf_pkg::CS_DIV : scsf_pkg::CS_COMMIT;
            end
         end
         scsf_pkg::CS_DIV: begin
            if (cnt_last) begin
               state_in = scsf_pkg::CS_COMMIT;
            end
         end
         scsf_pkg::CS_COMMIT: begin
            if (status.out_free) begin
               state_in = scsf_pkg::CS_WAIT;
            end
         end
         default: state_in = scsf_pkg::CS_WAIT;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.capture  = 1'b0;
      cmd.div_step = 1'b0;
      cmd.commit   = 1'b0;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         scsf_pkg::CS_WAIT: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            cnt_in      = '0;
         end
         scsf_pkg::CS_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         scsf_pkg::CS_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/core/scsf_dpath.sv */
`timescale 1ns / 1ps

module scsf_dpath #(
   parameter int PATTERN_MAX = scsf_pkg::PATTERN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [scsf_pkg::INDEX_W-1:0]  csr_index,
   input  logic [scsf_pkg::DATA_W-1:0]   csr_data,
   input  logic                          req_opcode,
   input  logic [2:0]                    req_resp_method,
   input  logic [31:0]                   req_resp_sequence,
   input  logic [7:0]                    req_resp_socket_id,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_has_request,
   output logic [1:0]                    rsp_req_method,
   output logic [7:0]                    rsp_req_socket,
   output logic [31:0]                   rsp_req_sequence,
   output logic [7:0]                    rsp_payload_start,
   output logic [15:0]                   rsp_payload_length,
   output logic [15:0]                   rsp_req_src_port,
   output logic [31:0]                   rsp_req_dst_address,
   output logic [15:0]                   rsp_req_dst_port,
   output logic [1:0]                    rsp_wake,
   output logic [2:0]                    rsp_response_status,
   input  scsf_pkg::dp_cmd_type          cmd,
   output scsf_pkg::dp_status_type       status
);

   // configuration
   logic [15:0]                 src_port_ff;
   logic [31:0]                 dst_addr_ff;
   logic [15:0]                 dst_port_ff;
   logic [scsf_pkg::PLEN_W-1:0] plen_cfg_ff;
   logic [31:0]                 total_ff;
   logic [15:0]                 chunk_ff;

   // connection state
   scsf_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         seq_ff, seq_in;
   logic [7:0]          sock_ff, sock_in;
   logic [31:0]         sent_ff, sent_in;

   // captured word
   logic        op_ff;
   logic [2:0]  meth_ff;
   logic [31:0] rseq_ff;
   logic [7:0]  rsock_ff;

   // divider
   logic [31:0]                 dvd_ff, dvd_in;
   logic [scsf_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [scsf_pkg::PLEN_W-1:0] plen_min;
   logic [scsf_pkg::PLEN_W-1:0] plen;

   // output register
   logic        valid_ff, valid_in;
   logic        has_ff, has_in;
   logic [1:0]  meth_out_ff, meth_out_in;
   logic [7:0]  sock_out_ff, sock_out_in;
   logic [31:0] seq_out_ff, seq_out_in;
   logic [7:0]  start_ff, start_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] srcp_ff, srcp_in;
   logic [31:0] dsta_ff, dsta_in;
   logic [15:0] dstp_ff, dstp_in;
   logic [1:0]  wake_ff, wake_in;
   logic [2:0]  stat_ff, stat_in;

   logic [31:0] left;
   logic [15:0] cmax;
   logic [15:0] len;

   assign plen_min = (plen_cfg_ff == '0) ? scsf_pkg::PLEN_W'(1) : plen_cfg_ff;
   assign plen     = (32'(plen_min) > 32'(PATTERN_MAX)) ?
                     scsf_pkg::PLEN_W'(PATTERN_MAX) : plen_min;

   assign status = '{
      need_div: (req_opcode == scsf_pkg::OP_TICK) &&
                (phase_ff == scsf_pkg::PH_WRITE) && (sent_ff < total_ff),
      out_free: !valid_ff || !rsp_stall
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         src_port_ff <= '0;
         dst_addr_ff <= '0;
         dst_port_ff <= '0;
         plen_cfg_ff <= scsf_pkg::PLEN_W'(1);
         total_ff    <= '0;
         chunk_ff    <= 16'd1024;
      end else if (csr_write) begin
         unique case (csr_index)
            scsf_pkg::CSR_SOURCE_PORT:  src_port_ff <= csr_data[15:0];
            scsf_pkg::CSR_DEST_ADDRESS: dst_addr_ff <= csr_data;
            scsf_pkg::CSR_DEST_PORT:    dst_port_ff <= csr_data[15:0];
            scsf_pkg::CSR_PATTERN_LEN:  plen_cfg_ff <= csr_data[scsf_pkg::PLEN_W-1:0];
            scsf_pkg::CSR_TOTAL_BYTES:  total_ff    <= csr_data;
            scsf_pkg::CSR_CHUNK_MAX:    chunk_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= scsf_pkg::PH_IDLE;
         seq_ff   <= '0;
         sock_ff  <= '0;
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         sock_ff  <= sock_in;
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         meth_ff  <= req_resp_method;
         rseq_ff  <= req_resp_sequence;
         rsock_ff <= req_resp_socket_id;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.commit) begin
         has_ff      <= has_in;
         meth_out_ff <= meth_out_in;
         sock_out_ff <= sock_out_in;
         seq_out_ff  <= seq_out_in;
         start_ff    <= start_in;
         len_ff      <= len_in;
         srcp_ff     <= srcp_in;
         dsta_ff     <= dsta_in;
         dstp_ff     <= dstp_in;
         wake_ff     <= wake_in;
         stat_ff     <= stat_in;
      end
   end

   // restoring remainder, four dividend bits a cycle
   always_comb begin
      logic [scsf_pkg::REM_W-1:0] r;
      logic [scsf_pkg::REM_W-1:0] t;
      logic [31:0]                d;
      r = rem_ff;
      d = dvd_ff;
      for (int i = 0; i < scsf_pkg::DIV_BITS; i++) begin
         t = {r[scsf_pkg::PLEN_W-1:0], d[31]};
         d = {d[30:0], 1'b0};
         if (t >= {1'b0, plen}) begin
            r = t - {1'b0, plen};
         end else begin
            r = t;
         end
      end
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (cmd.capture) begin
         dvd_in = sent_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = d;
         rem_in = r;
      end
   end

   assign left = total_ff - sent_ff;
   assign cmax = (chunk_ff == '0) ? 16'd1 : chunk_ff;
   assign len  = (left < {16'd0, cmax}) ? left[15:0] : cmax;

   always_comb begin
      phase_in    = phase_ff;
      seq_in      = seq_ff;
      sock_in     = sock_ff;
      sent_in     = sent_ff;
      has_in      = 1'b0;
      meth_out_in = scsf_pkg::M_NEW;
      sock_out_in = '0;
      seq_out_in  = '0;
      start_in    = '0;
      len_in      = '0;
      srcp_in     = '0;
      dsta_in     = '0;
      dstp_in     = '0;
      wake_in     = scsf_pkg::WAKE_NONE;
      stat_in     = scsf_pkg::ST_TICK;

      if (op_ff == scsf_pkg::OP_TICK) begin
         unique case (phase_ff)
            scsf_pkg::PH_IDLE: begin
               seq_in     = seq_ff + 32'd1;
               has_in     = 1'b1;
               seq_out_in = seq_ff + 32'd1;
               srcp_in    = src_port_ff;
            end
            scsf_pkg::PH_START: begin
               seq_in      = seq_ff + 32'd1;
               has_in      = 1'b1;
               meth_out_in = scsf_pkg::M_CONNECT;
               sock_out_in = sock_ff;
               seq_out_in  = seq_ff + 32'd1;
               dsta_in     = dst_addr_ff;
               dstp_in     = dst_port_ff;
            end
            scsf_pkg::PH_WRITE: begin
               has_in      = 1'b1;
               sock_out_in = sock_ff;
               if (sent_ff >= total_ff) begin
                  phase_in    = scsf_pkg::PH_CLOSE;
                  meth_out_in = scsf_pkg::M_CLOSE;
                  seq_out_in  = seq_ff;
               end else begin
                  seq_in      = seq_ff + 32'd1;
                  meth_out_in = scsf_pkg::M_SEND;
                  seq_out_in  = seq_ff + 32'd1;
                  start_in    = rem_ff[7:0];
                  len_in      = len;
                  sent_in     = sent_ff + {16'd0, len};
               end
            end
            scsf_pkg::PH_CLOSE: begin
               seq_in      = seq_ff + 32'd1;
               has_in      = 1'b1;
               meth_out_in = scsf_pkg::M_CLOSE;
               sock_out_in = sock_ff;
               seq_out_in  = seq_ff + 32'd1;
            end
            default: ;
         endcase
      end else if (rseq_ff != seq_ff) begin
         stat_in = scsf_pkg::ST_STALE;
      end else if (meth_ff == scsf_pkg::RESP_ERROR) begin
         if (phase_ff == scsf_pkg::PH_WRITE || phase_ff == scsf_pkg::PH_CLOSE ||
             phase_ff == scsf_pkg::PH_START) begin
            phase_in = (phase_ff == scsf_pkg::PH_CLOSE) ? scsf_pkg::PH_START :
                       scsf_pkg::PH_CLOSE;
            wake_in  = scsf_pkg::WAKE_NOW;
            stat_in  = scsf_pkg::ST_ACCEPTED;
         end else begin
            phase_in = scsf_pkg::PH_FAIL;
            stat_in  = scsf_pkg::ST_FAILED;
         end
      end else if (phase_ff == scsf_pkg::PH_IDLE && meth_ff == scsf_pkg::RESP_NEW) begin
         phase_in = scsf_pkg::PH_START;
         sock_in  = rsock_ff;
         wake_in  = scsf_pkg::WAKE_NOW;
         stat_in  = scsf_pkg::ST_ACCEPTED;
      end else if (phase_ff == scsf_pkg::PH_START && meth_ff == scsf_pkg::RESP_CONNECT) begin
         phase_in = scsf_pkg::PH_WRITE;
         sent_in  = '0;
         wake_in  = scsf_pkg::WAKE_NOW;
         stat_in  = scsf_pkg::ST_ACCEPTED;
      end else if (phase_ff == scsf_pkg::PH_WRITE && meth_ff == scsf_pkg::RESP_SEND) begin
         wake_in = scsf_pkg::WAKE_INTERVAL;
         stat_in = scsf_pkg::ST_ACCEPTED;
      end else if (phase_ff == scsf_pkg::PH_CLOSE && meth_ff == scsf_pkg::RESP_CLOSE) begin
         phase_in = scsf_pkg::PH_START;
         stat_in  = scsf_pkg::ST_ACCEPTED;
      end else begin
         stat_in = scsf_pkg::ST_UNEXPECTED;
      end

      // hold state unless this word commits
      if (!cmd.commit) begin
         phase_in = phase_ff;
         seq_in   = seq_ff;
         sock_in  = sock_ff;
         sent_in  = sent_ff;
      end
   end

   always_comb begin
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_has_request     = has_ff;
   assign rsp_req_method      = meth_out_ff;
   assign rsp_req_socket      = sock_out_ff;
   assign rsp_req_sequence    = seq_out_ff;
   assign rsp_payload_start   = start_ff;
   assign rsp_payload_length  = len_ff;
   assign rsp_req_src_port    = srcp_ff;
   assign rsp_req_dst_address = dsta_ff;
   assign rsp_req_dst_port    = dstp_ff;
   assign rsp_wake            = wake_ff;
   assign rsp_response_status = stat_ff;

endmodule

/* rtl/core/scsf_checker.sv */
`timescale 1ns / 1ps

module scsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_has_request,
   input logic [1:0]  rsp_req_method,
   input logic [7:0]  rsp_req_socket,
   input logic [31:0] rsp_req_sequence,
   input logic [7:0]  rsp_payload_start,
   input logic [15:0] rsp_payload_length,
   input logic [15:0] rsp_req_src_port,
   input logic [31:0] rsp_req_dst_address,
   input logic [15:0] rsp_req_dst_port,
   input logic [1:0]  rsp_wake,
   input logic [2:0]  rsp_response_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_req_sequence) &&
                                 $stable(rsp_response_status))
      else $error("stalled result changed");

   a_no_request_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_request |-> rsp_req_sequence == 32'd0 &&
         rsp_req_socket == 8'd0 && rsp_payload_length == 16'd0 &&
         rsp_req_src_port == 16'd0 && rsp_req_dst_address == 32'd0 &&
         rsp_req_dst_port == 16'd0)
      else $error("request fields set without a request");

   a_request_is_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_request |->
         rsp_wake == scsf_pkg::WAKE_NONE && rsp_response_status == scsf_pkg::ST_TICK)
      else $error("request issued on a response");

   a_payload_only_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_req_method != scsf_pkg::M_SEND |->
         rsp_payload_length == 16'd0 && rsp_payload_start == 8'd0)
      else $error("payload on a request other than send");

endmodule

bind stream_connection_sender_fsm scsf_checker u_scsf_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_has_request     (rsp_has_request),
   .rsp_req_method      (rsp_req_method),
   .rsp_req_socket      (rsp_req_socket),
   .rsp_req_sequence    (rsp_req_sequence),
   .rsp_payload_start   (rsp_payload_start),
   .rsp_payload_length  (rsp_payload_length),
   .rsp_req_src_port    (rsp_req_src_port),
   .rsp_req_dst_address (rsp_req_dst_address),
   .rsp_req_dst_port    (rsp_req_dst_port),
   .rsp_wake            (rsp_wake),
   .rsp_response_status (rsp_response_status)
);
